// ----- hw/rtl/hsc_pkg.sv -----
// Heater station controller package: command types, register indexes, constants.
// No dependencies; imported by every module of the controller.
`default_nettype none

package hsc_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] PATTERN_SLOW = 32'h0000FFFF;
    localparam logic [31:0] PATTERN_FAST = 32'hAAAAAAAA;

    localparam logic [9:0]  SETPOINT_MIN_RESET  = 10'd200;
    localparam logic [9:0]  SETPOINT_MAX_RESET  = 10'd450;
    localparam logic [5:0]  SUPPLY_MIN_RESET    = 6'd20;
    localparam logic [5:0]  SUPPLY_MAX_RESET    = 6'd26;
    localparam logic [7:0]  NEAR_BAND_RESET     = 8'd20;
    localparam logic [15:0] PWM_PERIOD_RESET    = 16'd20000;
    localparam logic [5:0]  PERSIST_DELAY_RESET = 6'd30;
    localparam logic [9:0]  SETPOINT_RESET      = 10'd200;
    localparam logic signed [10:0] LAST_TEMP_RESET = -11'sd1;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_MEASURE = 3'd1;
    localparam logic [2:0] FUNC_ENCODER = 3'd2;
    localparam logic [2:0] FUNC_BUTTON  = 3'd3;
    localparam logic [2:0] FUNC_RESTORE = 3'd4;

    localparam logic [2:0] CFG_SETPOINT_MIN  = 3'd0;
    localparam logic [2:0] CFG_SETPOINT_MAX  = 3'd1;
    localparam logic [2:0] CFG_SUPPLY_MIN    = 3'd2;
    localparam logic [2:0] CFG_SUPPLY_MAX    = 3'd3;
    localparam logic [2:0] CFG_NEAR_BAND     = 3'd4;
    localparam logic [2:0] CFG_PWM_PERIOD    = 3'd5;
    localparam logic [2:0] CFG_PERSIST_DELAY = 3'd6;

    typedef enum logic [2:0] {
        K_NONE,
        K_TICK,
        K_MEASURE,
        K_ENCODER,
        K_BUTTON,
        K_RESTORE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [10:0] measured_temp;
        logic [5:0]         measured_supply;
        logic [15:0]        encoder_count;
        logic [9:0]         restore_setpoint;
        logic [15:0]        restore_address;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsc_front.sv -----
// Front end: accepts input beats, classifies the function code, pushes commands.
// Depends on hsc_pkg; feeds hsc_queue.
`default_nettype none

module hsc_front (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         func,
    input  wire logic signed [10:0] measured_temp,
    input  wire logic [5:0]         measured_supply,
    input  wire logic [15:0]        encoder_count,
    input  wire logic [9:0]         restore_setpoint,
    input  wire logic [15:0]        restore_address,
    input  wire logic               queue_full,
    output logic                    push,
    output hsc_pkg::cmd_t           push_data
);
    import hsc_pkg::*;

    cmd_kind_t kind;

    always_comb
    begin
        unique case (func)
            FUNC_TICK:    kind = K_TICK;
            FUNC_MEASURE: kind = K_MEASURE;
            FUNC_ENCODER: kind = K_ENCODER;
            FUNC_BUTTON:  kind = K_BUTTON;
            FUNC_RESTORE: kind = K_RESTORE;
            default:      kind = K_NONE;
        endcase
    end

    assign in_stall = queue_full;
    // drop unused codes here
    assign push     = in_valid && !queue_full && (kind != K_NONE);

    always_comb
    begin
        push_data.kind             = kind;
        push_data.measured_temp    = measured_temp;
        push_data.measured_supply  = measured_supply;
        push_data.encoder_count    = encoder_count;
        push_data.restore_setpoint = restore_setpoint;
        push_data.restore_address  = restore_address;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsc_queue.sv -----
// Command queue between front and back end, QUEUE_DEPTH entries.
// Depends on hsc_pkg.
`default_nettype none

module hsc_queue (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire hsc_pkg::cmd_t push_data,
    output logic         full,
    input  wire logic    pop,
    output hsc_pkg::cmd_t pop_data,
    output logic         empty
);
    import hsc_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsc_back.sv -----
// Back end: configuration registers, controller state, tick evaluation, output register.
// Depends on hsc_pkg; pops commands from hsc_queue.
`default_nettype none

module hsc_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire hsc_pkg::cmd_t cmd,
    input  wire logic         queue_empty,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [15:0]       duty,
    output logic              led,
    output logic              heater_enabled,
    output logic              supply_fault,
    output logic              persist_write,
    output logic [15:0]       write_address,
    output logic [15:0]       clear_address,
    output logic [9:0]        setpoint_now
);
    import hsc_pkg::*;

    localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);

    function automatic logic [15:0] duty_thirty(input logic [15:0] period);
        logic [17:0] x;
        logic [35:0] prod;
        x    = {1'b0, period, 1'b0} + {2'b00, period} + 18'd5;
        prod = 36'(x) * 36'd209716;
        return {1'b0, prod[35:21]};
    endfunction

    logic [9:0]  setpoint_min_reg, setpoint_max_reg;
    logic [5:0]  supply_min_reg, supply_max_reg;
    logic [7:0]  near_band_reg;
    logic [15:0] pwm_period_reg, duty30_reg;
    logic [5:0]  persist_delay_reg;

    logic [4:0]  blink_pos_reg, blink_pos_next;
    logic        blink_fast_reg, blink_fast_next;
    logic        heater_on_reg, heater_on_next;
    logic        paused_reg, paused_next;
    logic        start_req_reg, start_req_next;
    logic        stop_req_reg, stop_req_next;
    logic        force_reg, force_next;
    logic [9:0]  setpoint_reg, setpoint_next;
    logic [9:0]  last_setpoint_reg, last_setpoint_next;
    logic signed [10:0] temp_reg, temp_next;
    logic signed [10:0] last_temp_reg, last_temp_next;
    logic [5:0]  supply_reg, supply_next;
    logic [15:0] duty_reg, duty_next;
    logic [5:0]  persist_count_reg, persist_count_next;
    logic        persist_pending_reg, persist_pending_next;
    logic [15:0] store_addr_reg, store_addr_next;

    logic        out_valid_reg;
    logic        led_reg, led_next;
    logic        fault_reg, fault_next;
    logic        wr_reg, wr_next;
    logic [15:0] waddr_reg, waddr_next;
    logic [15:0] caddr_reg, caddr_next;

    logic        out_free;
    logic        tick;
    logic signed [12:0] diff;
    logic [16:0] addr_inc;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = !queue_empty && ((cmd.kind != K_TICK) || out_free);
    assign tick      = pop && (cmd.kind == K_TICK);
    assign addr_inc  = {1'b0, store_addr_reg} + 17'd2;

    always_comb
    begin
        blink_pos_next       = blink_pos_reg;
        blink_fast_next      = blink_fast_reg;
        heater_on_next       = heater_on_reg;
        paused_next          = paused_reg;
        start_req_next       = start_req_reg;
        stop_req_next        = stop_req_reg;
        force_next           = force_reg;
        setpoint_next        = setpoint_reg;
        last_setpoint_next   = last_setpoint_reg;
        temp_next            = temp_reg;
        last_temp_next       = last_temp_reg;
        supply_next          = supply_reg;
        duty_next            = duty_reg;
        persist_count_next   = persist_count_reg;
        persist_pending_next = persist_pending_reg;
        store_addr_next      = store_addr_reg;
        led_next             = 1'b0;
        fault_next           = 1'b0;
        wr_next              = 1'b0;
        waddr_next           = '0;
        caddr_next           = '0;
        diff                 = 13'(signed'({3'b000, setpoint_reg})) - 13'(temp_reg);

        if (pop)
        begin
            unique case (cmd.kind)
                K_TICK:
                begin
                    led_next = blink_fast_reg ? PATTERN_FAST[blink_pos_reg]
                                              : PATTERN_SLOW[blink_pos_reg];
                    blink_pos_next = blink_pos_reg + 1'b1;
                    fault_next = (supply_reg < supply_min_reg) || (supply_reg > supply_max_reg);
                    if (fault_next)
                    begin
                        if (heater_on_reg && !paused_reg)
                        begin
                            paused_next    = 1'b1;
                            heater_on_next = 1'b0;
                        end
                    end
                    else if (start_req_reg)
                    begin
                        if (!heater_on_reg)
                        begin
                            heater_on_next = 1'b1;
                            paused_next    = 1'b0;
                            force_next     = 1'b1;
                        end
                    end
                    else if (stop_req_reg)
                        heater_on_next = 1'b0;
                    else if (paused_reg)
                    begin
                        paused_next = 1'b0;
                        if (!heater_on_reg)
                        begin
                            heater_on_next = 1'b1;
                            force_next     = 1'b1;
                        end
                    end

                    if (heater_on_next && !paused_next)
                    begin
                        if (force_next || (last_temp_reg != temp_reg)
                            || (last_setpoint_reg != setpoint_reg))
                        begin
                            if (diff < 0)
                            begin
                                duty_next       = '0;
                                blink_fast_next = 1'b0;
                            end
                            else if (diff <= 13'(signed'({5'b00000, near_band_reg})))
                            begin
                                duty_next       = duty30_reg;
                                blink_fast_next = 1'b1;
                            end
                            else
                            begin
                                duty_next       = pwm_period_reg;
                                blink_fast_next = 1'b1;
                            end
                            force_next = 1'b0;
                        end
                    end
                    else
                    begin
                        duty_next       = '0;
                        blink_fast_next = 1'b0;
                    end

                    last_temp_next     = temp_reg;
                    last_setpoint_next = setpoint_reg;
                    start_req_next     = 1'b0;
                    stop_req_next      = 1'b0;

                    if (persist_pending_reg)
                    begin
                        if (persist_count_reg == '0)
                        begin
                            wr_next    = 1'b1;
                            waddr_next = (addr_inc >= STORE_LIMIT) ? 16'd0 : addr_inc[15:0];
                            caddr_next = store_addr_reg;
                            store_addr_next = waddr_next;
                            persist_pending_next = 1'b0;
                        end
                        else
                            persist_count_next = persist_count_reg - 1'b1;
                    end
                end
                K_MEASURE:
                begin
                    temp_next   = cmd.measured_temp;
                    supply_next = cmd.measured_supply;
                end
                K_ENCODER:
                begin
                    if (heater_on_reg && (cmd.encoder_count != {6'd0, setpoint_reg}))
                    begin
                        persist_count_next   = persist_delay_reg;
                        persist_pending_next = 1'b1;
                        if (cmd.encoder_count < {6'd0, setpoint_min_reg})
                            setpoint_next = setpoint_min_reg;
                        else if (cmd.encoder_count > {6'd0, setpoint_max_reg})
                            setpoint_next = setpoint_max_reg;
                        else
                            setpoint_next = cmd.encoder_count[9:0];
                    end
                end
                K_BUTTON:
                begin
                    start_req_next = !heater_on_reg;
                    stop_req_next  = heater_on_reg;
                end
                K_RESTORE:
                begin
                    if (cmd.restore_setpoint != '0)
                    begin
                        if ((cmd.restore_setpoint > setpoint_max_reg)
                            || (cmd.restore_setpoint < setpoint_min_reg))
                            setpoint_next = setpoint_min_reg;
                        else
                            setpoint_next = cmd.restore_setpoint;
                    end
                    store_addr_next = cmd.restore_address;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_min_reg  <= SETPOINT_MIN_RESET;
            setpoint_max_reg  <= SETPOINT_MAX_RESET;
            supply_min_reg    <= SUPPLY_MIN_RESET;
            supply_max_reg    <= SUPPLY_MAX_RESET;
            near_band_reg     <= NEAR_BAND_RESET;
            pwm_period_reg    <= PWM_PERIOD_RESET;
            duty30_reg        <= duty_thirty(PWM_PERIOD_RESET);
            persist_delay_reg <= PERSIST_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SETPOINT_MIN:  setpoint_min_reg  <= cfg_data[9:0];
                CFG_SETPOINT_MAX:  setpoint_max_reg  <= cfg_data[9:0];
                CFG_SUPPLY_MIN:    supply_min_reg    <= cfg_data[5:0];
                CFG_SUPPLY_MAX:    supply_max_reg    <= cfg_data[5:0];
                CFG_NEAR_BAND:     near_band_reg     <= cfg_data[7:0];
                CFG_PWM_PERIOD:
                begin
                    pwm_period_reg <= cfg_data;
                    duty30_reg     <= duty_thirty(cfg_data);
                end
                CFG_PERSIST_DELAY: persist_delay_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_pos_reg       <= '0;
            blink_fast_reg      <= 1'b0;
            heater_on_reg       <= 1'b0;
            paused_reg          <= 1'b0;
            start_req_reg       <= 1'b0;
            stop_req_reg        <= 1'b0;
            force_reg           <= 1'b1;
            setpoint_reg        <= SETPOINT_RESET;
            last_setpoint_reg   <= '0;
            temp_reg            <= '0;
            last_temp_reg       <= LAST_TEMP_RESET;
            supply_reg          <= '0;
            duty_reg            <= '0;
            persist_count_reg   <= '0;
            persist_pending_reg <= 1'b0;
            store_addr_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            blink_pos_reg       <= blink_pos_next;
            blink_fast_reg      <= blink_fast_next;
            heater_on_reg       <= heater_on_next;
            paused_reg          <= paused_next;
            start_req_reg       <= start_req_next;
            stop_req_reg        <= stop_req_next;
            force_reg           <= force_next;
            setpoint_reg        <= setpoint_next;
            last_setpoint_reg   <= last_setpoint_next;
            temp_reg            <= temp_next;
            last_temp_reg       <= last_temp_next;
            supply_reg          <= supply_next;
            duty_reg            <= duty_next;
            persist_count_reg   <= persist_count_next;
            persist_pending_reg <= persist_pending_next;
            store_addr_reg      <= store_addr_next;
            if (tick)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // hold result beat until taken
    logic [15:0] out_duty_reg;
    logic        out_on_reg;
    logic [9:0]  out_setpoint_reg;

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            out_duty_reg     <= duty_next;
            led_reg          <= led_next;
            out_on_reg       <= heater_on_next;
            fault_reg        <= fault_next;
            wr_reg           <= wr_next;
            waddr_reg        <= waddr_next;
            caddr_reg        <= caddr_next;
            out_setpoint_reg <= setpoint_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty           = out_duty_reg;
    assign led            = led_reg;
    assign heater_enabled = out_on_reg;
    assign supply_fault   = fault_reg;
    assign persist_write  = wr_reg;
    assign write_address  = waddr_reg;
    assign clear_address  = caddr_reg;
    assign setpoint_now   = out_setpoint_reg;

    a_tick_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> out_valid_reg)
        else $error("tick popped without a result beat");

    a_on_not_paused: assert property (@(posedge clk) disable iff (!rst_n)
        !(heater_on_reg && paused_reg))
        else $error("heater both running and paused");

    a_no_write_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !wr_reg) |-> (waddr_reg == '0 && caddr_reg == '0))
        else $error("addresses set without a persist write");

    a_setpoint_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(setpoint_reg))
        else $error("setpoint changed without a command");

endmodule

`default_nettype wire

// ----- hw/rtl/heater_station_controller.sv -----
// Heater station controller top level: front end, command queue, back end.
// Depends on hsc_pkg, hsc_front, hsc_queue, hsc_back.
//
// One event beat is taken per clock while the four-entry command queue has room; the back
// end executes one command per cycle unless a tick waits on the output register, so the
// sustained rate is one beat per cycle while results are taken. A tick's result is loaded
// into the output register when the back end pops it; a tick at the head of the queue waits
// there only while the single output register still holds an untaken result; other events
// produce no result. Configuration writes are always accepted and take effect for commands executed afterwards.
`default_nettype none

module heater_station_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         func,
    input  wire logic signed [10:0] measured_temp,
    input  wire logic [5:0]         measured_supply,
    input  wire logic [15:0]        encoder_count,
    input  wire logic [9:0]         restore_setpoint,
    input  wire logic [15:0]        restore_address,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             duty,
    output logic                    led,
    output logic                    heater_enabled,
    output logic                    supply_fault,
    output logic                    persist_write,
    output logic [15:0]             write_address,
    output logic [15:0]             clear_address,
    output logic [9:0]              setpoint_now
);
    import hsc_pkg::*;

    cmd_t push_data;
    cmd_t pop_data;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    hsc_front u_front (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .measured_temp    (measured_temp),
        .measured_supply  (measured_supply),
        .encoder_count    (encoder_count),
        .restore_setpoint (restore_setpoint),
        .restore_address  (restore_address),
        .queue_full       (queue_full),
        .push             (push),
        .push_data        (push_data)
    );

    hsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    hsc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (pop_data),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty           (duty),
        .led            (led),
        .heater_enabled (heater_enabled),
        .supply_fault   (supply_fault),
        .persist_write  (persist_write),
        .write_address  (write_address),
        .clear_address  (clear_address),
        .setpoint_now   (setpoint_now)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for heater_station_controller: event stream in, tick reports out.
// Depends on hsc_pkg and the controller RTL; predicts every tick report and compares fields.

module tb_top;
    import hsc_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_SPACING    = 500;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PRINT_LIMIT     = 100;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [10:0] temp;
        logic [5:0]         supply;
        logic [15:0]        enc;
        logic [9:0]         rsp;
        logic [15:0]        raddr;
    } heat_event_t;

    typedef struct packed {
        logic [15:0] duty;
        logic        led;
        logic        heater_enabled;
        logic        supply_fault;
        logic        persist_write;
        logic [15:0] write_address;
        logic [15:0] clear_address;
        logic [9:0]  setpoint_now;
    } tick_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         func = '0;
    logic signed [10:0] measured_temp = '0;
    logic [5:0]         measured_supply = '0;
    logic [15:0]        encoder_count = '0;
    logic [9:0]         restore_setpoint = '0;
    logic [15:0]        restore_address = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        duty;
    logic               led;
    logic               heater_enabled;
    logic               supply_fault;
    logic               persist_write;
    logic [15:0]        write_address;
    logic [15:0]        clear_address;
    logic [9:0]         setpoint_now;

    heater_station_controller u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .measured_temp    (measured_temp),
        .measured_supply  (measured_supply),
        .encoder_count    (encoder_count),
        .restore_setpoint (restore_setpoint),
        .restore_address  (restore_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .duty             (duty),
        .led              (led),
        .heater_enabled   (heater_enabled),
        .supply_fault     (supply_fault),
        .persist_write    (persist_write),
        .write_address    (write_address),
        .clear_address    (clear_address),
        .setpoint_now     (setpoint_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the limits and controller state
    logic [9:0]         lim_sp_min, lim_sp_max;
    logic [5:0]         lim_sup_min, lim_sup_max;
    logic [7:0]         lim_band;
    logic [15:0]        lim_period;
    logic [5:0]         lim_delay;
    logic [4:0]         blink_pos;
    bit                 blink_fast, heat_on, heat_paused, start_req, stop_req;
    bit                 force_rc, store_pending;
    logic [9:0]         setpt, prev_setpt;
    logic signed [10:0] temp_now, prev_temp;
    logic [5:0]         supply_now;
    logic [15:0]        duty_reg;
    logic [5:0]         store_count;
    logic [15:0]        store_addr;

    heat_event_t  events_to_send[$];
    tick_result_t tick_results[$];
    heat_event_t  drv_item = '0;
    int           gap_left;
    int           beats_in;
    int           stall_left;
    int           hold_left;
    int           next_hold_at;
    int           mismatches = 0;
    bit           steady = 1'b0;
    int           gen_sp_lo, gen_sp_hi, gen_sup_lo, gen_sup_hi;

    task automatic flag_error(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] ERROR %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit heater_step(input heat_event_t ev, output tick_result_t r);
        logic [31:0] pattern;
        logic [15:0] v;
        logic [9:0]  rv;
        bit          fault;
        int          sp_i, t_i, band_i, diff, nxt_i;
        r = '0;
        case (ev.func)
            FUNC_TICK:
            begin
                pattern = blink_fast ? PATTERN_FAST : PATTERN_SLOW;
                r.led = pattern[blink_pos];
                blink_pos = blink_pos + 5'd1;
                fault = supply_now < lim_sup_min || supply_now > lim_sup_max;
                if (fault)
                begin
                    if (heat_on && !heat_paused)
                    begin
                        heat_paused = 1'b1;
                        heat_on = 1'b0;
                    end
                end
                else if (start_req)
                begin
                    if (!heat_on)
                    begin
                        heat_on = 1'b1;
                        heat_paused = 1'b0;
                        force_rc = 1'b1;
                    end
                end
                else if (stop_req)
                    heat_on = 1'b0;
                else if (heat_paused)
                begin
                    heat_paused = 1'b0;
                    if (!heat_on)
                    begin
                        heat_on = 1'b1;
                        force_rc = 1'b1;
                    end
                end
                if (heat_on && !heat_paused)
                begin
                    if (force_rc || prev_temp != temp_now || prev_setpt != setpt)
                    begin
                        sp_i = setpt;
                        t_i = temp_now;
                        band_i = lim_band;
                        diff = sp_i - t_i;
                        if (diff < 0)
                        begin
                            duty_reg = '0;
                            blink_fast = 1'b0;
                        end
                        else if (diff <= band_i)
                        begin
                            nxt_i = lim_period;
                            nxt_i = (nxt_i * 3 + 5) / 10;
                            duty_reg = nxt_i[15:0];
                            blink_fast = 1'b1;
                        end
                        else
                        begin
                            duty_reg = lim_period;
                            blink_fast = 1'b1;
                        end
                        force_rc = 1'b0;
                    end
                end
                else
                begin
                    duty_reg = '0;
                    blink_fast = 1'b0;
                end
                prev_temp = temp_now;
                prev_setpt = setpt;
                start_req = 1'b0;
                stop_req = 1'b0;
                if (store_pending)
                begin
                    if (store_count == 0)
                    begin
                        nxt_i = store_addr;
                        nxt_i += 2;
                        r.persist_write = 1'b1;
                        r.write_address = (nxt_i >= STORE_BYTES) ? 16'd0 : nxt_i[15:0];
                        r.clear_address = store_addr;
                        store_addr = r.write_address;
                        store_pending = 1'b0;
                    end
                    else
                        store_count = store_count - 6'd1;
                end
                r.duty = duty_reg;
                r.heater_enabled = heat_on;
                r.supply_fault = fault;
                r.setpoint_now = setpt;
                return 1'b1;
            end
            FUNC_MEASURE:
            begin
                temp_now = ev.temp;
                supply_now = ev.supply;
            end
            FUNC_ENCODER:
            begin
                v = ev.enc;
                if (heat_on && v != {6'd0, setpt})
                begin
                    store_count = lim_delay;
                    store_pending = 1'b1;
                    if (v < {6'd0, lim_sp_min})
                        v = {6'd0, lim_sp_min};
                    else if (v > {6'd0, lim_sp_max})
                        v = {6'd0, lim_sp_max};
                    setpt = v[9:0];
                end
            end
            FUNC_BUTTON:
            begin
                start_req = !heat_on;
                stop_req = heat_on;
            end
            FUNC_RESTORE:
            begin
                rv = ev.rsp;
                if (rv != 0)
                begin
                    if (rv > lim_sp_max || rv < lim_sp_min)
                        rv = lim_sp_min;
                    setpt = rv;
                end
                store_addr = ev.raddr;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic heat_event_t ev_of(input logic [2:0] f, input int t, input int s,
                                          input int e, input int rs, input int ra);
        heat_event_t r;
        r.func = f;
        r.temp = t[10:0];
        r.supply = s[5:0];
        r.enc = e[15:0];
        r.rsp = rs[9:0];
        r.raddr = ra[15:0];
        return r;
    endfunction

    function automatic heat_event_t make_event();
        int r, t, s, e, rs, ra;
        logic [2:0] f;
        r = $urandom_range(0, 99);
        if (r < 42)
            f = FUNC_TICK;
        else if (r < 64)
            f = FUNC_MEASURE;
        else if (r < 80)
            f = FUNC_ENCODER;
        else if (r < 90)
            f = FUNC_BUTTON;
        else if (r < 97)
            f = FUNC_RESTORE;
        else
            f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));

        if ($urandom_range(0, 9) == 0)
            t = $urandom_range(0, 1535);
        else
        begin
            t = $urandom_range(gen_sp_lo, gen_sp_hi);
            r = $urandom_range(0, 80);
            t = t + r - 50;
            t = t + 512;
        end
        t = (t < 0) ? -512 : (t > 1535) ? 1023 : t - 512;

        if ($urandom_range(0, 4) != 0)
            s = $urandom_range(gen_sup_lo, gen_sup_hi);
        else
            s = $urandom_range(0, 63);

        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            e = $urandom_range(gen_sp_lo, gen_sp_hi);
            r = $urandom_range(0, 20);
            e = e + r - 10;
            if (e < 0)
                e = 0;
        end
        else if (r < 9)
            e = $urandom_range(0, 1023);
        else
            e = $urandom_range(0, 65535);

        r = $urandom_range(0, 9);
        rs = (r < 5) ? $urandom_range(gen_sp_lo, gen_sp_hi) :
             (r < 7) ? 0 : $urandom_range(0, 1023);

        r = $urandom_range(0, 9);
        if (r < 4)
            ra = 65520 + 2 * $urandom_range(0, 7);
        else if (r < 8)
            ra = 2 * $urandom_range(0, 32767);
        else if (r < 9)
            ra = 2 * $urandom_range(0, 32766) + 1;
        else
            ra = 0;
        return ev_of(f, t, s, e, rs, ra);
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (events_to_send.size() != 0 || in_valid || tick_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SETPOINT_MIN:  lim_sp_min = val[9:0];
            CFG_SETPOINT_MAX:  lim_sp_max = val[9:0];
            CFG_SUPPLY_MIN:    lim_sup_min = val[5:0];
            CFG_SUPPLY_MAX:    lim_sup_max = val[5:0];
            CFG_NEAR_BAND:     lim_band = val[7:0];
            CFG_PWM_PERIOD:    lim_period = val;
            CFG_PERSIST_DELAY: lim_delay = val[5:0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic program_limits(input int sp_min, input int sp_max, input int sup_min,
                                  input int sup_max, input int band, input int period,
                                  input int delay);
        wait_idle();
        write_reg(CFG_SETPOINT_MIN, sp_min[15:0]);
        write_reg(CFG_SETPOINT_MAX, sp_max[15:0]);
        write_reg(CFG_SUPPLY_MIN, sup_min[15:0]);
        write_reg(CFG_SUPPLY_MAX, sup_max[15:0]);
        write_reg(CFG_NEAR_BAND, band[15:0]);
        write_reg(CFG_PWM_PERIOD, period[15:0]);
        write_reg(CFG_PERSIST_DELAY, delay[15:0]);
    endtask

    task automatic run_phase(input int count, input bit quiet);
        @(negedge clk);
        steady = quiet;
        gen_sp_lo = (lim_sp_min < lim_sp_max) ? lim_sp_min : lim_sp_max;
        gen_sp_hi = (lim_sp_min < lim_sp_max) ? lim_sp_max : lim_sp_min;
        gen_sup_lo = (lim_sup_min < lim_sup_max) ? lim_sup_min : lim_sup_max;
        gen_sup_hi = (lim_sup_min < lim_sup_max) ? lim_sup_max : lim_sup_min;
        repeat (count) events_to_send.push_back(make_event());
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        tick_result_t res;
        heat_event_t  nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            beats_in <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                beats_in <= beats_in + 1;
                if (heater_step(drv_item, res))
                    tick_results.push_back(res);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (events_to_send.size() != 0)
                begin
                    nxt = events_to_send.pop_front();
                    drv_item <= nxt;
                    func <= nxt.func;
                    measured_temp <= nxt.temp;
                    measured_supply <= nxt.supply;
                    encoder_count <= nxt.enc;
                    restore_setpoint <= nxt.rsp;
                    restore_address <= nxt.raddr;
                    in_valid <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // hold off the output now and then long enough to back up the command queue
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            next_hold_at <= HOLD_OFF_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (beats_in >= next_hold_at)
        begin
            hold_left <= HOLD_OFF_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tick_results.size() == 0)
                flag_error("result beat with no tick outstanding");
            else
            begin
                want = tick_results.pop_front();
                if (duty != want.duty)
                    flag_error($sformatf("duty got %0d want %0d", duty, want.duty));
                if (led != want.led)
                    flag_error($sformatf("led got %0d want %0d", led, want.led));
                if (heater_enabled != want.heater_enabled)
                    flag_error($sformatf("heater_enabled got %0d want %0d",
                                         heater_enabled, want.heater_enabled));
                if (supply_fault != want.supply_fault)
                    flag_error($sformatf("supply_fault got %0d want %0d",
                                         supply_fault, want.supply_fault));
                if (persist_write != want.persist_write)
                    flag_error($sformatf("persist_write got %0d want %0d",
                                         persist_write, want.persist_write));
                if (write_address != want.write_address)
                    flag_error($sformatf("write_address got %0d want %0d",
                                         write_address, want.write_address));
                if (clear_address != want.clear_address)
                    flag_error($sformatf("clear_address got %0d want %0d",
                                         clear_address, want.clear_address));
                if (setpoint_now != want.setpoint_now)
                    flag_error($sformatf("setpoint_now got %0d want %0d",
                                         setpoint_now, want.setpoint_now));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** heater_station_controller: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        lim_sp_min = SETPOINT_MIN_RESET;
        lim_sp_max = SETPOINT_MAX_RESET;
        lim_sup_min = SUPPLY_MIN_RESET;
        lim_sup_max = SUPPLY_MAX_RESET;
        lim_band = NEAR_BAND_RESET;
        lim_period = PWM_PERIOD_RESET;
        lim_delay = PERSIST_DELAY_RESET;
        blink_pos = '0;
        blink_fast = 1'b0;
        heat_on = 1'b0;
        heat_paused = 1'b0;
        start_req = 1'b0;
        stop_req = 1'b0;
        force_rc = 1'b1;
        store_pending = 1'b0;
        setpt = SETPOINT_RESET;
        prev_setpt = '0;
        temp_now = '0;
        prev_temp = LAST_TEMP_RESET;
        supply_now = '0;
        duty_reg = '0;
        store_count = '0;
        store_addr = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, -512, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, 1023, 63, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, 190, 24, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_ENCODER, 0, 0, 300, 0, 0));
        events_to_send.push_back(ev_of(FUNC_BUTTON, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_ENCODER, 0, 0, 65535, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_ENCODER, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, 500, 24, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, 200, 30, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_BUTTON, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_MEASURE, 200, 20, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_ENCODER, 0, 0, 200, 0, 0));
        events_to_send.push_back(ev_of(FUNC_RESTORE, 0, 0, 0, 0, 65534));
        events_to_send.push_back(ev_of(FUNC_RESTORE, 0, 0, 0, 1000, 65532));
        events_to_send.push_back(ev_of(FUNC_BUTTON, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_UNUSED_LO, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_UNUSED_HI, 0, 0, 0, 0, 0));
        events_to_send.push_back(ev_of(FUNC_TICK, 0, 0, 0, 0, 0));

        program_limits(180, 500, 18, 28, 25, 20000, 1);
        run_phase(250, 1'b0);
        program_limits(0, 1023, 0, 63, 255, 65535, 0);
        run_phase(250, 1'b1);
        program_limits(1023, 1023, 63, 63, 0, 1, 63);
        run_phase(250, 1'b0);
        program_limits(0, 0, 0, 0, 0, 65535, 3);
        run_phase(250, 1'b0);
        program_limits($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
                       $urandom_range(1, 65535), $urandom_range(0, 7));
        run_phase(250, 1'b0);
        program_limits($urandom_range(100, 400), $urandom_range(400, 900),
                       $urandom_range(0, 20), $urandom_range(20, 63), $urandom_range(0, 255),
                       $urandom_range(1, 65535), $urandom_range(0, 4));
        run_phase(250, 1'b1);

        wait_idle();
        if (mismatches == 0)
            $display("** heater_station_controller: PASSED **");
        else
            $display("** heater_station_controller: FAILED **");
        $finish;
    end

endmodule
